// File: design/point_in_polygon_test_assert.svh
// Assertion macros for the point in polygon block checker.
// Needs i_clk and i_rst_n visible where a macro is used.
`ifndef POINT_IN_POLYGON_TEST_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define PIP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define PIP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/pip_pkg.sv
// Shared types and constants for the point in polygon block.
// No dependencies.
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    localparam int COORD_W      = 16;
    localparam int WORD_W       = 2 * COORD_W;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int CROSS_W      = DIFF_W + 2;
    localparam int TOTAL_W      = 7;

    localparam int DIV_STEPS    = DIFF_W;
    localparam int STEP_W       = $clog2(DIV_STEPS);

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_TEST   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_PREV,
        S_EDGE,
        S_MUL,
        S_DSETUP,
        S_DIV,
        S_CROSS
    } t_state;

endpackage

// File: design/pip_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/point_in_polygon_test.sv
// Point in polygon block, top level: vertex table, edge sequencer, shared divider.
// Depends on pip_pkg and pip_ram.
//
// Crossing-number point in polygon test over a vertex table of up to
// pip_pkg::MAX_VERTICES entries. A word is taken when start is high and busy
// is low; i_cmd picks clear, append or test. Every word gives exactly one
// result, shown for one cycle with o_strobe high; the receiver cannot stall,
// so results must be captured in that cycle. Clear, append, an unused command
// and a test on an empty table never raise busy: the result appears in the
// cycle after the word is taken and a new word may be taken in that same
// cycle. A test keeps busy high while it loads the last vertex, walks each
// edge in turn and, for each edge that straddles the point's y, runs a
// multiply, a divider setup, the division and a compare; the result
// appears as busy falls. The cost is set by the shared divider, which
// resolves one quotient bit per cycle. Vertices sit in one RAM with a
// registered read, fetched in order with the previous vertex held in
// registers, so each edge needs a single read. An append to a full table
// stores nothing and reports o_status high. o_vertex_total is the count
// held after the word, in 7 bits.
module point_in_polygon_test (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic [1:0]                          i_cmd,
    input  logic signed [pip_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [pip_pkg::COORD_W-1:0]  i_coord_y,
    output logic                                busy,
    output logic                                o_strobe,
    output logic                                o_inside_res,
    output logic                                o_status,
    output logic [pip_pkg::TOTAL_W-1:0]         o_vertex_total
);

    // Sequencer state
    pip_pkg::t_state r_state, n_state;

    // Vertex count and edge walk
    logic [pip_pkg::CNT_W-1:0]  r_count, n_count;
    logic [pip_pkg::ADDR_W-1:0] r_idx, n_idx;
    logic                       r_flag, n_flag;

    // Test point and previous vertex
    logic signed [pip_pkg::COORD_W-1:0] r_px, n_px, r_py, n_py;
    logic signed [pip_pkg::COORD_W-1:0] r_prev_x, n_prev_x, r_prev_y, n_prev_y;
    logic signed [pip_pkg::COORD_W-1:0] r_xi, n_xi;

    // Edge operands, product, divider
    logic signed [pip_pkg::DIFF_W-1:0]  r_dx, n_dx, r_dy, n_dy, r_den, n_den;
    logic signed [pip_pkg::PROD_W-1:0]  r_prod, n_prod;
    logic [pip_pkg::DIFF_W-1:0]         r_den_mag, n_den_mag;
    logic [pip_pkg::DIFF_W-1:0]         r_rem, n_rem;
    logic [pip_pkg::DIFF_W-1:0]         r_quo, n_quo;
    logic                               r_neg, n_neg;
    logic [pip_pkg::STEP_W-1:0]         r_step, n_step;

    // Result registers
    logic                         r_strobe, n_strobe;
    logic                         r_inside, n_inside;
    logic                         r_status, n_status;
    logic [pip_pkg::TOTAL_W-1:0]  r_total, n_total;

    // RAM port
    logic                        w_wr_en, w_rd_en;
    logic [pip_pkg::ADDR_W-1:0]  w_wr_addr, w_rd_addr;
    logic [pip_pkg::WORD_W-1:0]  w_wr_data, w_rd_data;

    logic signed [pip_pkg::COORD_W-1:0] w_cur_x, w_cur_y;
    logic                               w_accept, w_last, w_straddle;
    logic [pip_pkg::PROD_W-1:0]         w_prod_mag;
    logic [pip_pkg::DIFF_W:0]           w_trial;
    logic                               w_ge;
    logic signed [pip_pkg::DIFF_W:0]    w_q;
    logic signed [pip_pkg::CROSS_W-1:0] w_cross;
    logic                               w_lt;

    pip_ram #(
        .WIDTH (pip_pkg::WORD_W),
        .DEPTH (pip_pkg::MAX_VERTICES)
    ) u_vertex_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign busy     = (r_state != pip_pkg::S_IDLE);
    assign w_accept = start && !busy;

    // RAM word is {x, y}
    assign w_cur_x = w_rd_data[pip_pkg::WORD_W-1:pip_pkg::COORD_W];
    assign w_cur_y = w_rd_data[pip_pkg::COORD_W-1:0];

    // Edge from previous vertex (j) to current (i) straddles py
    assign w_straddle = (w_cur_y > r_py) != (r_prev_y > r_py);
    assign w_last     = (pip_pkg::CNT_W'(r_idx) == r_count - pip_pkg::CNT_W'(1));

    // Divider datapath: one restoring step per cycle
    assign w_prod_mag = r_prod[pip_pkg::PROD_W-1] ? pip_pkg::PROD_W'(-r_prod)
                                                  : pip_pkg::PROD_W'(r_prod);
    assign w_trial = {r_rem, r_quo[pip_pkg::DIFF_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den_mag});

    // Signed quotient (truncated toward zero) plus xi, compared with px
    assign w_q     = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign w_cross = pip_pkg::CROSS_W'(w_q) + pip_pkg::CROSS_W'(r_xi);
    assign w_lt    = (pip_pkg::CROSS_W'(r_px) < w_cross);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pip_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_flag    <= n_flag;
        r_px      <= n_px;
        r_py      <= n_py;
        r_prev_x  <= n_prev_x;
        r_prev_y  <= n_prev_y;
        r_xi      <= n_xi;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_den     <= n_den;
        r_prod    <= n_prod;
        r_den_mag <= n_den_mag;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_neg     <= n_neg;
        r_step    <= n_step;
        r_inside  <= n_inside;
        r_status  <= n_status;
        r_total   <= n_total;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_flag    = r_flag;
        n_px      = r_px;
        n_py      = r_py;
        n_prev_x  = r_prev_x;
        n_prev_y  = r_prev_y;
        n_xi      = r_xi;
        n_dx      = r_dx;
        n_dy      = r_dy;
        n_den     = r_den;
        n_prod    = r_prod;
        n_den_mag = r_den_mag;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_neg     = r_neg;
        n_step    = r_step;
        n_strobe  = 1'b0;
        n_inside  = r_inside;
        n_status  = r_status;
        n_total   = r_total;

        w_wr_en   = 1'b0;
        w_wr_addr = r_count[pip_pkg::ADDR_W-1:0];
        w_wr_data = {i_coord_x, i_coord_y};
        w_rd_en   = 1'b0;
        w_rd_addr = r_idx;

        unique case (r_state)
            pip_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_strobe = 1'b1;
                    n_inside = 1'b0;
                    n_status = 1'b0;
                    n_total  = pip_pkg::TOTAL_W'(r_count);
                    unique case (i_cmd)
                        pip_pkg::CMD_CLEAR: begin
                            n_count = '0;
                            n_total = '0;
                        end
                        pip_pkg::CMD_APPEND: begin
                            if (r_count < pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES)) begin
                                w_wr_en = 1'b1;
                                n_count = r_count + pip_pkg::CNT_W'(1);
                                n_total = pip_pkg::TOTAL_W'(n_count);
                            end else begin
                                n_status = 1'b1;
                            end
                        end
                        pip_pkg::CMD_TEST: begin
                            if (r_count != '0) begin
                                // start with the last vertex as j
                                n_strobe  = 1'b0;
                                w_rd_en   = 1'b1;
                                w_rd_addr = pip_pkg::ADDR_W'(r_count - pip_pkg::CNT_W'(1));
                                n_idx     = '0;
                                n_flag    = 1'b0;
                                n_px      = i_coord_x;
                                n_py      = i_coord_y;
                                n_state   = pip_pkg::S_LOAD_PREV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pip_pkg::S_LOAD_PREV: begin
                n_prev_x  = w_cur_x;
                n_prev_y  = w_cur_y;
                w_rd_en   = 1'b1;
                w_rd_addr = '0;
                n_state   = pip_pkg::S_EDGE;
            end
            pip_pkg::S_EDGE: begin
                // rd data is vertex i; prefetch i+1 (held until used)
                n_xi      = w_cur_x;
                n_dx      = pip_pkg::DIFF_W'(r_prev_x) - pip_pkg::DIFF_W'(w_cur_x);
                n_dy      = pip_pkg::DIFF_W'(r_py) - pip_pkg::DIFF_W'(w_cur_y);
                n_den     = pip_pkg::DIFF_W'(r_prev_y) - pip_pkg::DIFF_W'(w_cur_y);
                n_prev_x  = w_cur_x;
                n_prev_y  = w_cur_y;
                w_rd_en   = 1'b1;
                w_rd_addr = r_idx + pip_pkg::ADDR_W'(1);
                if (w_straddle) begin
                    n_state = pip_pkg::S_MUL;
                end else if (w_last) begin
                    n_strobe = 1'b1;
                    n_inside = r_flag;
                    n_status = 1'b0;
                    n_total  = pip_pkg::TOTAL_W'(r_count);
                    n_state  = pip_pkg::S_IDLE;
                end else begin
                    n_idx = r_idx + pip_pkg::ADDR_W'(1);
                end
            end
            pip_pkg::S_MUL: begin
                n_prod  = r_dx * r_dy;
                n_state = pip_pkg::S_DSETUP;
            end
            pip_pkg::S_DSETUP: begin
                // |quotient| <= |dx| < 2^17, so the high half starts below den
                n_rem     = w_prod_mag[pip_pkg::PROD_W-1:pip_pkg::DIFF_W];
                n_quo     = w_prod_mag[pip_pkg::DIFF_W-1:0];
                n_den_mag = r_den[pip_pkg::DIFF_W-1] ? pip_pkg::DIFF_W'(-r_den)
                                                     : pip_pkg::DIFF_W'(r_den);
                n_neg     = r_prod[pip_pkg::PROD_W-1] ^ r_den[pip_pkg::DIFF_W-1];
                n_step    = '0;
                n_state   = pip_pkg::S_DIV;
            end
            pip_pkg::S_DIV: begin
                n_rem = w_ge ? pip_pkg::DIFF_W'(w_trial - {1'b0, r_den_mag})
                             : pip_pkg::DIFF_W'(w_trial);
                n_quo = {r_quo[pip_pkg::DIFF_W-2:0], w_ge};
                n_step = r_step + pip_pkg::STEP_W'(1);
                if (r_step == pip_pkg::STEP_W'(pip_pkg::DIV_STEPS - 1)) begin
                    n_state = pip_pkg::S_CROSS;
                end
            end
            pip_pkg::S_CROSS: begin
                n_flag = r_flag ^ w_lt;
                if (w_last) begin
                    n_strobe = 1'b1;
                    n_inside = r_flag ^ w_lt;
                    n_status = 1'b0;
                    n_total  = pip_pkg::TOTAL_W'(r_count);
                    n_state  = pip_pkg::S_IDLE;
                end else begin
                    n_idx   = r_idx + pip_pkg::ADDR_W'(1);
                    n_state = pip_pkg::S_EDGE;
                end
            end
            default: begin
                n_state = pip_pkg::S_IDLE;
            end
        endcase
    end

    assign o_strobe       = r_strobe;
    assign o_inside_res   = r_inside;
    assign o_status       = r_status;
    assign o_vertex_total = r_total;

endmodule

// File: design/pip_checker.sv
// Port-level checker for the point in polygon block, bound to the top level.
// Depends on pip_pkg and point_in_polygon_test_assert.svh.
`include "point_in_polygon_test_assert.svh"

module pip_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic [1:0]                          i_cmd,
    input  logic signed [pip_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [pip_pkg::COORD_W-1:0]  i_coord_y,
    input  logic                                busy,
    input  logic                                o_strobe,
    input  logic                                o_inside_res,
    input  logic                                o_status,
    input  logic [pip_pkg::TOTAL_W-1:0]         o_vertex_total
);

    // non-test words answer in the very next cycle
    `PIP_ASSERT_NXT(a_quick_result, start && !busy && i_cmd != pip_pkg::CMD_TEST, o_strobe, "missing result for clear or append word")

    // a finished test always shows its result as busy drops
    `PIP_ASSERT_IMP(a_test_done, !busy && $past(busy), o_strobe, "busy fell without a result")

    // results only appear while idle
    `PIP_ASSERT_IMP(a_strobe_idle, o_strobe, !busy, "result shown while busy")

    // a dropped append means the table is full
    `PIP_ASSERT_IMP(a_full_status, o_strobe && o_status, o_vertex_total == pip_pkg::TOTAL_W'(pip_pkg::MAX_VERTICES) && !o_inside_res, "full flag with table not full")

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (.*);

// File: verif/point_in_polygon_test_tb.sv
// Self-checking testbench for point_in_polygon_test: directed and random vertex table
// traffic, each result compared against a crossing-number predictor in a scoreboard.
// Depends on pip_pkg and the point_in_polygon_test RTL.
module point_in_polygon_test_tb;

    // Command code the block leaves unused: it changes nothing and echoes the count.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [pip_pkg::COORD_W-1:0] C_MIN = 16'sh8000;
    localparam logic signed [pip_pkg::COORD_W-1:0] C_MAX = 16'sh7FFF;

    localparam int WORDS_WANTED = 540;

    // One result word as the block should report it.
    typedef struct {
        logic                         in_poly;
        logic                         status;
        logic [pip_pkg::TOTAL_W-1:0]  total;
    } t_vertex_answer;

    // Tracks the vertex table and queues the answer due for every accepted word.
    class t_polygon_tracker;
        logic signed [pip_pkg::COORD_W-1:0] vert_x [pip_pkg::MAX_VERTICES];
        logic signed [pip_pkg::COORD_W-1:0] vert_y [pip_pkg::MAX_VERTICES];
        int                                 held;
        t_vertex_answer                     answers_due [$];
        int                                 mismatches;

        function new();
            held       = 0;
            mismatches = 0;
        endfunction

        // Crossing-number test: walk edges (j -> i), j starting at the last vertex.
        function bit point_within(logic signed [pip_pkg::COORD_W-1:0] px,
                                  logic signed [pip_pkg::COORD_W-1:0] py);
            longint xi, yi, xj, yj, x_cross, pxl, pyl;
            bit     flag;
            int     j;
            flag = 1'b0;
            pxl  = px;
            pyl  = py;
            if (held == 0)
                return 1'b0;
            j = held - 1;
            for (int i = 0; i < held; i++) begin
                xi = vert_x[i];
                yi = vert_y[i];
                xj = vert_x[j];
                yj = vert_y[j];
                // exactly one end strictly above the test y; divisor cannot be zero
                if ((yi > pyl) != (yj > pyl)) begin
                    // SV longint division truncates toward zero, as the block does
                    x_cross = (xj - xi) * (pyl - yi) / (yj - yi) + xi;
                    if (pxl < x_cross)
                        flag = ~flag;
                end
                j = i;
            end
            return flag;
        endfunction

        function void take_word(logic [1:0] cmd, logic signed [pip_pkg::COORD_W-1:0] x,
                                logic signed [pip_pkg::COORD_W-1:0] y);
            t_vertex_answer a;
            a.in_poly = 1'b0;
            a.status  = 1'b0;
            case (cmd)
                pip_pkg::CMD_CLEAR: begin
                    held = 0;
                end
                pip_pkg::CMD_APPEND: begin
                    if (held < pip_pkg::MAX_VERTICES) begin
                        vert_x[held] = x;
                        vert_y[held] = y;
                        held++;
                    end else begin
                        a.status = 1'b1;   // table full, vertex dropped
                    end
                end
                pip_pkg::CMD_TEST: begin
                    a.in_poly = point_within(x, y);
                end
                default: ;
            endcase
            a.total = pip_pkg::TOTAL_W'(held);
            answers_due = {answers_due, a};
        endfunction

        function void match_answer(logic got_in, logic status,
                                   logic [pip_pkg::TOTAL_W-1:0] total);
            t_vertex_answer want;
            if (answers_due.size() == 0) begin
                $error("unexpected result: inside_res %0d status %0d vertex_total %0d",
                       got_in, status, total);
                mismatches++;
                return;
            end
            want = answers_due.pop_front();
            if (got_in !== want.in_poly) begin
                $error("inside_res: expected %0d, actual %0d", want.in_poly, got_in);
                mismatches++;
            end
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                mismatches++;
            end
            if (total !== want.total) begin
                $error("vertex_total: expected %0d, actual %0d", want.total, total);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return answers_due.size();
        endfunction
    endclass

    logic                                i_clk;
    logic                                i_rst_n   = 1'b0;
    logic                                start     = 1'b0;
    logic [1:0]                          i_cmd     = pip_pkg::CMD_CLEAR;
    logic signed [pip_pkg::COORD_W-1:0]  i_coord_x = '0;
    logic signed [pip_pkg::COORD_W-1:0]  i_coord_y = '0;
    logic                                busy;
    logic                                o_strobe;
    logic                                o_inside_res;
    logic                                o_status;
    logic [pip_pkg::TOTAL_W-1:0]         o_vertex_total;

    t_polygon_tracker tracker = new();

    int words_sent = 0;     // accepted words, unused command not counted
    int burst_left = 0;     // words left before the next sender gap

    point_in_polygon_test dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_cmd          (i_cmd),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .busy           (busy),
        .o_strobe       (o_strobe),
        .o_inside_res   (o_inside_res),
        .o_status       (o_status),
        .o_vertex_total (o_vertex_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Monitor. Results are checked before the word of this edge is noted: a
    // result never shows up in the cycle its word is taken, so order is safe.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe === 1'b1)
                tracker.match_answer(o_inside_res, o_status, o_vertex_total);
            if (start && busy === 1'b0)
                tracker.take_word(i_cmd, i_coord_x, i_coord_y);
        end
    end

    // Random coordinate in [-span, span].
    function automatic logic signed [pip_pkg::COORD_W-1:0] rand_coord(int span);
        return pip_pkg::COORD_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // Tiny spans give many shared vertex y values and horizontal edges;
    // the widest span exercises the full crossing arithmetic.
    function automatic int pick_span();
        case ($urandom_range(0, 3))
            0:       return 4;
            1:       return 60;
            2:       return 3000;
            default: return 32767;
        endcase
    endfunction

    // Present one word, hold it until taken, then pace the sender:
    // bursts of random length separated by random gaps.
    task automatic send_word(input logic [1:0] cmd,
                             input logic signed [pip_pkg::COORD_W-1:0] x,
                             input logic signed [pip_pkg::COORD_W-1:0] y);
        start     <= 1'b1;
        i_cmd     <= cmd;
        i_coord_x <= x;
        i_coord_y <= y;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (cmd != CMD_UNUSED)
            words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // idle with garbage on the payload
            start     <= 1'b0;
            i_cmd     <= 2'($urandom_range(0, 3));
            i_coord_x <= pip_pkg::COORD_W'($urandom);
            i_coord_y <= pip_pkg::COORD_W'($urandom);
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    // Stop sending until every outstanding result has been seen.
    // Polled on the falling edge so the monitor's update is settled.
    task automatic drain();
        start <= 1'b0;
        do @(negedge i_clk); while (tracker.outstanding() != 0);
        @(posedge i_clk);
    endtask

    // Build a polygon of n vertices (optionally onto the current table) and
    // probe it. n past the table size exercises the dropped-append path.
    task automatic build_and_probe(input bit fresh, input int n, input int probes);
        int span;
        span = pick_span();
        if (fresh)
            send_word(pip_pkg::CMD_CLEAR, pip_pkg::COORD_W'($urandom),
                      pip_pkg::COORD_W'($urandom));
        repeat (n) send_word(pip_pkg::CMD_APPEND, rand_coord(span), rand_coord(span));
        repeat (probes) send_word(pip_pkg::CMD_TEST, rand_coord(span), rand_coord(span));
    endtask

    initial begin
        int pick;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, unused command, extreme square, right triangle.
        send_word(pip_pkg::CMD_TEST, 16'sd0, 16'sd0);
        send_word(CMD_UNUSED, C_MIN, C_MAX);
        send_word(pip_pkg::CMD_APPEND, C_MIN, C_MIN);
        send_word(pip_pkg::CMD_APPEND, C_MAX, C_MIN);
        send_word(pip_pkg::CMD_APPEND, C_MAX, C_MAX);
        send_word(pip_pkg::CMD_APPEND, C_MIN, C_MAX);
        send_word(pip_pkg::CMD_TEST, 16'sd0, 16'sd0);
        send_word(pip_pkg::CMD_TEST, C_MIN, 16'sd0);
        send_word(pip_pkg::CMD_TEST, C_MAX, 16'sd0);
        send_word(pip_pkg::CMD_TEST, 16'sd0, C_MIN);
        send_word(pip_pkg::CMD_TEST, C_MAX, C_MAX);
        send_word(CMD_UNUSED, 16'sd0, 16'sd0);
        send_word(pip_pkg::CMD_CLEAR, C_MAX, C_MIN);
        send_word(pip_pkg::CMD_TEST, 16'sd5, 16'sd5);
        // triangle with a horizontal base; probes inside, on edges and outside
        send_word(pip_pkg::CMD_APPEND, 16'sd0, 16'sd0);
        send_word(pip_pkg::CMD_APPEND, 16'sd10, 16'sd0);
        send_word(pip_pkg::CMD_APPEND, 16'sd0, 16'sd10);
        send_word(pip_pkg::CMD_TEST, 16'sd2, 16'sd2);
        send_word(pip_pkg::CMD_TEST, 16'sd0, 16'sd5);
        send_word(pip_pkg::CMD_TEST, 16'sd9, 16'sd0);
        send_word(pip_pkg::CMD_TEST, -16'sd1, 16'sd5);

        // Quiet pause, then a full table with overflow appends.
        drain();
        build_and_probe(1'b1, pip_pkg::MAX_VERTICES + 2, 2);

        // Random: mostly small polygons, some appended onto the old
        // table, some full-table runs, and bursts of raw noise.
        while (words_sent < WORDS_WANTED) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                drain();
            if (pick < 65)
                build_and_probe($urandom_range(0, 4) != 0,
                                ($urandom_range(0, 9) != 0)
                                    ? $urandom_range(3, 8)
                                    : $urandom_range(1, pip_pkg::MAX_VERTICES),
                                $urandom_range(1, 6));
            else if (pick < 68)
                build_and_probe(1'b1, pip_pkg::MAX_VERTICES + $urandom_range(1, 3),
                                $urandom_range(1, 3));
            else
                repeat ($urandom_range(1, 8))
                    send_word(2'($urandom_range(0, 3)), pip_pkg::COORD_W'($urandom),
                              pip_pkg::COORD_W'($urandom));
        end

        drain();
        // then keep clocking to catch any stray strobe
        repeat (50) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #8000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
